[design/ohash_pkg.sv]
// package for the open-addressing hash table
// types, codes and constants shared by every module of the block
// no dependencies

package ohash_pkg;

	// sizes fixed by the field layout
	localparam int KEY_W       = 31;
	localparam int TSIZE_W     = 7;
	localparam int SLOT_IDX_W  = 6;
	localparam int MAX_SLOTS_D = 64;
	localparam logic [TSIZE_W-1:0] TSIZE_RST = 7'd64;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RES_OK   = 2'd0,
		RES_DUP  = 2'd1,
		RES_MISS = 2'd2,
		RES_FULL = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_LIVE  = 2'd1,
		SLOT_TOMB  = 2'd2
	} slot_st_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'd0,
		ST_IDLE  = 2'd1,
		ST_MOD   = 2'd2,
		ST_PROBE = 2'd3
	} state_t;

	// one command transfer
	typedef struct packed {
		op_t              opcode;
		logic [KEY_W-1:0] key;
	} cmd_t;

	// one result transfer
	typedef struct packed {
		outcome_t              outcome;
		logic [SLOT_IDX_W-1:0] slot_index;
	} res_t;

	// one entry of the slot memory
	typedef struct packed {
		slot_st_t         status;
		logic [KEY_W-1:0] key;
	} slot_t;

endpackage

[design/open_addressing_hash_table.sv]
// top level of the open-addressing hash table with linear probing
// depends on ohash_pkg, ohash_mod and ohash_mem
//
// usage
//   a command (opcode, key) transfers at a rising edge with start high and
//   busy low. exactly one result (outcome, slot_index) follows, shown for one
//   cycle with done high; the receiver has no way to hold it off.
//   cfg_we writes cfg_data into the size register at any edge; write it only
//   while busy is low and no result is pending.
// operation
//   search and remove: the home index comes from the bit-serial remainder,
//   then slots are probed in turn from home until the key, an empty slot, or
//   until as many slots as the table size have been visited; then the result.
//   insert that misses: a second pass from home looks for a non-live slot.
//   clear: one slot written per cycle, then the result.
//   busy is high for the whole of a command, so one command is in work at a
//   time; a new one may start in the cycle done is shown.
// reset
//   the table size returns to 64 and a clearing pass empties every slot;
//   busy stays high meanwhile and no result is given for it.

module open_addressing_hash_table #(
	parameter int MAX_SLOTS = ohash_pkg::MAX_SLOTS_D
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ohash_pkg::cmd_t               cmd,
	output logic                          done,
	output ohash_pkg::res_t               result,
	input  logic                          cfg_we,
	input  logic [ohash_pkg::TSIZE_W-1:0] cfg_data
);

	localparam int SZ_W  = $clog2(MAX_SLOTS + 1);
	localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CMP_W = (SZ_W > ohash_pkg::TSIZE_W) ? SZ_W : ohash_pkg::TSIZE_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SLOTS - 1);

	ohash_pkg::state_t            state_q, state_d;
	logic [ohash_pkg::TSIZE_W-1:0] tsize_q;
	ohash_pkg::op_t               op_q;
	logic [ohash_pkg::KEY_W-1:0]  key_q;
	logic [SZ_W-1:0]              size_q;
	logic [IDX_W-1:0]             home_q, home_d;
	logic [IDX_W-1:0]             cur_q, cur_d;
	logic [SZ_W-1:0]              cnt_q, cnt_d;
	logic                         ins_pass_q, ins_pass_d;
	logic [IDX_W-1:0]             clr_idx_q, clr_idx_d;
	logic                         clr_report_q, clr_report_d;
	logic                         done_q, done_d;
	ohash_pkg::res_t              res_q, res_d;

	logic [CMP_W-1:0]             ts_ext;
	logic [SZ_W-1:0]              eff_size;
	logic                         accept;
	logic                         mod_go;
	logic                         mod_ready;
	logic [IDX_W-1:0]             mod_rem;
	logic                         mem_we;
	logic [IDX_W-1:0]             mem_waddr;
	ohash_pkg::slot_t             mem_wdata;
	logic [IDX_W-1:0]             mem_raddr;
	ohash_pkg::slot_t             mem_rdata;
	logic                         is_live;
	logic                         is_empty;
	logic                         key_hit;
	logic                         last_probe;
	logic                         wrap;
	logic [IDX_W-1:0]             nxt;

	// slot number masked to the width of the result field
	function automatic logic [ohash_pkg::SLOT_IDX_W-1:0] SLOT_IDX(input logic [IDX_W-1:0] idx);
		return ohash_pkg::SLOT_IDX_W'(idx);
	endfunction

	// table size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= ohash_pkg::TSIZE_RST;
		end else if (cfg_we) begin
			tsize_q <= cfg_data;
		end
	end

	// effective size: zero counts as one, saturate at the memory depth
	always_comb begin
		ts_ext = CMP_W'(tsize_q);
		if (ts_ext == '0) begin
			eff_size = SZ_W'(1);
		end else if (ts_ext > CMP_W'(MAX_SLOTS)) begin
			eff_size = SZ_W'(MAX_SLOTS);
		end else begin
			eff_size = SZ_W'(ts_ext);
		end
	end

	assign busy   = (state_q != ohash_pkg::ST_IDLE);
	assign accept = start && !busy;
	assign mod_go = accept && (cmd.opcode != ohash_pkg::OP_CLEAR);

	ohash_mod #(
		.MAX_SLOTS (MAX_SLOTS),
		.SZ_W      (SZ_W),
		.IDX_W     (IDX_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (mod_go),
		.dividend (cmd.key),
		.divisor  (eff_size),
		.ready    (mod_ready),
		.rem      (mod_rem)
	);

	ohash_mem #(
		.MAX_SLOTS (MAX_SLOTS),
		.IDX_W     (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// classify the slot read for cur_q and find the next probe address
	always_comb begin
		is_live    = (mem_rdata.status == ohash_pkg::SLOT_LIVE);
		is_empty   = (mem_rdata.status == ohash_pkg::SLOT_EMPTY);
		key_hit    = is_live && (mem_rdata.key == key_q);
		last_probe = ((cnt_q + SZ_W'(1)) == size_q);
		wrap       = ((SZ_W'(cur_q) + SZ_W'(1)) == size_q);
		nxt        = wrap ? '0 : cur_q + IDX_W'(1);
	end

	// next state, probe sequencing and memory requests
	always_comb begin
		state_d      = state_q;
		home_d       = home_q;
		cur_d        = cur_q;
		cnt_d        = cnt_q;
		ins_pass_d   = ins_pass_q;
		clr_idx_d    = clr_idx_q;
		clr_report_d = clr_report_q;
		done_d       = 1'b0;
		res_d        = res_q;
		mem_we       = 1'b0;
		mem_waddr    = cur_q;
		mem_wdata    = '{status: ohash_pkg::SLOT_LIVE, key: key_q};
		mem_raddr    = home_q;
		case (state_q)
			ohash_pkg::ST_CLEAR: begin
				// sweep every slot back to empty
				mem_we    = 1'b1;
				mem_waddr = clr_idx_q;
				mem_wdata = '{status: ohash_pkg::SLOT_EMPTY, key: '0};
				if (clr_idx_q == LAST_IDX) begin
					clr_idx_d = '0;
					state_d   = ohash_pkg::ST_IDLE;
					if (clr_report_q) begin
						done_d = 1'b1;
						res_d  = '{outcome: ohash_pkg::RES_OK, slot_index: '0};
					end
				end else begin
					clr_idx_d = clr_idx_q + IDX_W'(1);
				end
			end
			ohash_pkg::ST_IDLE: begin
				if (accept) begin
					ins_pass_d = 1'b0;
					if (cmd.opcode == ohash_pkg::OP_CLEAR) begin
						clr_idx_d    = '0;
						clr_report_d = 1'b1;
						state_d      = ohash_pkg::ST_CLEAR;
					end else begin
						state_d = ohash_pkg::ST_MOD;
					end
				end
			end
			ohash_pkg::ST_MOD: begin
				// home index ready: read it and start probing
				if (mod_ready) begin
					mem_raddr = mod_rem;
					home_d    = mod_rem;
					cur_d     = mod_rem;
					cnt_d     = '0;
					state_d   = ohash_pkg::ST_PROBE;
				end
			end
			ohash_pkg::ST_PROBE: begin
				// default: read ahead at the next slot
				mem_raddr = nxt;
				cur_d     = nxt;
				cnt_d     = cnt_q + SZ_W'(1);
				if (!ins_pass_q) begin
					if (key_hit) begin
						done_d  = 1'b1;
						state_d = ohash_pkg::ST_IDLE;
						res_d   = '{outcome: ohash_pkg::RES_OK,
							slot_index: SLOT_IDX(cur_q)};
						case (op_q)
							ohash_pkg::OP_INSERT: begin
								res_d.outcome = ohash_pkg::RES_DUP;
							end
							ohash_pkg::OP_REMOVE: begin
								mem_we    = 1'b1;
								mem_wdata = '{status: ohash_pkg::SLOT_TOMB, key: key_q};
							end
							default: begin
							end
						endcase
					end else if (is_empty || last_probe) begin
						if (op_q == ohash_pkg::OP_INSERT) begin
							// key absent: second pass from home for a free slot
							ins_pass_d = 1'b1;
							mem_raddr  = home_q;
							cur_d      = home_q;
							cnt_d      = '0;
						end else begin
							done_d  = 1'b1;
							state_d = ohash_pkg::ST_IDLE;
							res_d   = '{outcome: ohash_pkg::RES_MISS, slot_index: '0};
						end
					end
				end else begin
					if (!is_live) begin
						mem_we  = 1'b1;
						done_d  = 1'b1;
						state_d = ohash_pkg::ST_IDLE;
						res_d   = '{outcome: ohash_pkg::RES_OK,
							slot_index: SLOT_IDX(cur_q)};
					end else if (last_probe) begin
						done_d  = 1'b1;
						state_d = ohash_pkg::ST_IDLE;
						res_d   = '{outcome: ohash_pkg::RES_FULL, slot_index: '0};
					end
				end
			end
			default: begin
				state_d = ohash_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ohash_pkg::ST_CLEAR;
			clr_idx_q    <= '0;
			clr_report_q <= 1'b0;
			ins_pass_q   <= 1'b0;
			cnt_q        <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			clr_idx_q    <= clr_idx_d;
			clr_report_q <= clr_report_d;
			ins_pass_q   <= ins_pass_d;
			cnt_q        <= cnt_d;
			done_q       <= done_d;
		end
	end

	// command and probe payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd.opcode;
			key_q  <= cmd.key;
			size_q <= eff_size;
		end
		home_q <= home_d;
		cur_q  <= cur_d;
		res_q  <= res_d;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

[design/ohash_mod.sv]
// bit-serial remainder unit: key mod table size, one quotient bit a cycle
// depends on ohash_pkg

module ohash_mod #(
	parameter int MAX_SLOTS = ohash_pkg::MAX_SLOTS_D,
	parameter int SZ_W      = $clog2(MAX_SLOTS + 1),
	parameter int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [ohash_pkg::KEY_W-1:0] dividend,
	input  logic [SZ_W-1:0]           divisor,
	output logic                      ready,
	output logic [IDX_W-1:0]          rem
);

	localparam int CNT_W = $clog2(ohash_pkg::KEY_W + 1);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ohash_pkg::KEY_W - 1);

	logic [SZ_W-1:0]               rem_q;
	logic [ohash_pkg::KEY_W-1:0]   dvd_q;
	logic [SZ_W-1:0]               dsr_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          run_q;
	logic                          ready_q;
	logic [SZ_W:0]                 trial;
	logic [SZ_W:0]                 diff;
	logic [SZ_W-1:0]               rem_nxt;

	// shift in the next dividend bit and subtract when it fits
	always_comb begin
		trial   = {rem_q, dvd_q[ohash_pkg::KEY_W-1]};
		diff    = trial - {1'b0, dsr_q};
		rem_nxt = (trial >= {1'b0, dsr_q}) ? diff[SZ_W-1:0] : trial[SZ_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			ready_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			ready_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST_STEP) begin
					run_q   <= 1'b0;
					ready_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[ohash_pkg::KEY_W-2:0], 1'b0};
		end
	end

	assign ready = ready_q;
	assign rem   = IDX_W'(rem_q);

endmodule

[design/ohash_mem.sv]
// slot memory: status and key of every slot, one write and one read port
// read data registered, valid in the cycle after the address; depends on ohash_pkg

module ohash_mem #(
	parameter int MAX_SLOTS = ohash_pkg::MAX_SLOTS_D,
	parameter int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  ohash_pkg::slot_t wdata,
	input  logic [IDX_W-1:0] raddr,
	output ohash_pkg::slot_t rdata
);

	ohash_pkg::slot_t mem [MAX_SLOTS];
	ohash_pkg::slot_t rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[bench/hash_table_checker.sv]
// checker for the open-addressing hash table: mirrors the slot memory and
// table size, predicts the result of every command and compares it
// depends on ohash_pkg

module hash_table_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  ohash_pkg::cmd_t               cmd,
	input  logic                          done,
	input  ohash_pkg::res_t               result,
	input  logic                          cfg_we,
	input  logic [ohash_pkg::TSIZE_W-1:0] cfg_data,
	output int                            awaited,
	output int                            mismatches
);
	import ohash_pkg::*;

	// mirror of the slot memory and the size register
	slot_st_t             mirror_state [MAX_SLOTS_D];
	logic [KEY_W-1:0]     mirror_key   [MAX_SLOTS_D];
	logic [TSIZE_W-1:0]   mirror_size;
	res_t                 awaited_results [$];
	res_t                 oldest;
	int                   error_total = 0;

	assign mismatches = error_total;

	// size in use: zero counts as one, anything above the memory saturates
	function automatic int unsigned span();
		int unsigned n;
		n = mirror_size;
		if (n == 0) n = 1;
		if (n > MAX_SLOTS_D) n = MAX_SLOTS_D;
		return n;
	endfunction

	// walk from home past tombstones and other keys until an empty slot, the live key or every slot has been seen
	function automatic bit locate(logic [KEY_W-1:0] k, int unsigned n_slots,
			output int unsigned where);
		int unsigned pos;
		int unsigned step;
		bit stop;
		bit hit;
		pos = k % n_slots;
		hit = 0;
		stop = 0;
		where = 0;
		for (step = 0; step < n_slots && !stop; step++) begin
			if (mirror_state[pos] == SLOT_EMPTY) begin
				stop = 1;
			end else if (mirror_state[pos] == SLOT_LIVE && mirror_key[pos] == k) begin
				hit = 1;
				stop = 1;
				where = pos;
			end else begin
				pos = (pos + 1 == n_slots) ? 0 : pos + 1;
			end
		end
		return hit;
	endfunction

	// apply one command to the mirror and return the result it should give
	function automatic res_t apply_command(cmd_t c);
		int unsigned n_slots;
		int unsigned where;
		int unsigned pos;
		int unsigned step;
		bit placed;
		res_t r;
		n_slots = span();
		r.outcome = RES_OK;
		r.slot_index = '0;
		case (c.opcode)
			OP_INSERT: begin
				if (locate(c.key, n_slots, where)) begin
					r.outcome = RES_DUP;
					r.slot_index = SLOT_IDX_W'(where);
				end else begin
					// first non-live slot from home takes the key
					pos = c.key % n_slots;
					placed = 0;
					for (step = 0; step < n_slots && !placed; step++) begin
						if (mirror_state[pos] != SLOT_LIVE) begin
							mirror_key[pos] = c.key;
							mirror_state[pos] = SLOT_LIVE;
							r.slot_index = SLOT_IDX_W'(pos);
							placed = 1;
						end else begin
							pos = (pos + 1 == n_slots) ? 0 : pos + 1;
						end
					end
					if (!placed) r.outcome = RES_FULL;
				end
			end
			OP_SEARCH, OP_REMOVE: begin
				if (locate(c.key, n_slots, where)) begin
					if (c.opcode == OP_REMOVE) mirror_state[where] = SLOT_TOMB;
					r.slot_index = SLOT_IDX_W'(where);
				end else begin
					r.outcome = RES_MISS;
				end
			end
			default: begin
				foreach (mirror_state[i]) mirror_state[i] = SLOT_EMPTY;
			end
		endcase
		return r;
	endfunction

	// watch the command, result and configuration transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (mirror_state[i]) mirror_state[i] = SLOT_EMPTY;
			mirror_size = TSIZE_RST;
			awaited_results.delete();
			awaited <= 0;
		end else begin
			// result transfer against the oldest prediction
			if (done) begin
				if (awaited_results.size() == 0) begin
					$error("result with nothing awaited: outcome %0d slot_index %0d",
						result.outcome, result.slot_index);
					error_total++;
				end else begin
					oldest = awaited_results.pop_front();
					if (result.outcome !== oldest.outcome) begin
						$error("outcome: expected %0d, got %0d",
							oldest.outcome, result.outcome);
						error_total++;
					end
					if (result.slot_index !== oldest.slot_index) begin
						$error("slot_index: expected %0d, got %0d",
							oldest.slot_index, result.slot_index);
						error_total++;
					end
				end
			end
			if (cfg_we) mirror_size = cfg_data;
			// command transfer
			if (start && !busy) awaited_results.push_back(apply_command(cmd));
			awaited <= awaited_results.size();
		end
	end

endmodule

[bench/tb.sv]
// testbench top for the open-addressing hash table: clock, reset, command
// and size stimulus, and the verdict
// depends on ohash_pkg, open_addressing_hash_table and hash_table_checker

module tb;
	import ohash_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 200;
	localparam int ROUNDS       = 11;
	localparam int ROUND_ITEMS  = 60;
	localparam logic [KEY_W-1:0] KEY_TOP = '1;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	cmd_t               cmd;
	logic               done;
	res_t               result;
	logic               cfg_we;
	logic [TSIZE_W-1:0] cfg_data;
	int                 awaited;
	int                 mismatches;
	int                 cycle_count;
	bit                 steady;
	logic [KEY_W-1:0]   key_pool [16];
	int                 pool_len;

	open_addressing_hash_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	hash_table_checker check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.done       (done),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.awaited    (awaited),
		.mismatches (mismatches)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb NOT OK");
		$finish;
	end

	// random pause between commands, with noise on the idle command lines
	task automatic idle_gap();
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (r < 50) len = 0;
		else if (r < 90) len = $urandom_range(1, 3);
		else len = $urandom_range(10, 40);
		if (len > 0) begin
			start <= 1'b0;
			cmd <= cmd_t'($urandom);
			repeat (len) @(posedge clk);
		end
	endtask

	// one command transfer, start left high when the next follows at once
	task automatic issue(op_t op, logic [KEY_W-1:0] k);
		cmd <= '{opcode: op, key: k};
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (!steady) idle_gap();
	endtask

	// size write once every awaited result is in and the block is idle
	task automatic set_size(logic [TSIZE_W-1:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (awaited != 0 || busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// keys for one round: random, small, colliding on home and near the top
	task automatic build_pool(int unsigned n_slots);
		int unsigned base;
		base = $urandom_range(0, 1000);
		pool_len = (n_slots + 3 > 16) ? 16 : n_slots + 3;
		for (int i = 0; i < pool_len; i++) begin
			case ($urandom_range(0, 3))
				0: key_pool[i] = KEY_W'($urandom);
				1: key_pool[i] = KEY_W'($urandom_range(0, 255));
				2: key_pool[i] = KEY_W'(base + i * n_slots);
				default: key_pool[i] = KEY_TOP - KEY_W'($urandom_range(0, 3));
			endcase
		end
	endtask

	function automatic op_t pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return OP_INSERT;
		if (r < 70) return OP_SEARCH;
		if (r < 95) return OP_REMOVE;
		return OP_CLEAR;
	endfunction

	// stimulus and verdict
	initial begin
		logic [TSIZE_W-1:0] new_size;
		int unsigned n_slots;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		steady = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// full size: collisions, wrap, duplicates, tombstones
		issue(OP_SEARCH, 31'd0);
		issue(OP_INSERT, 31'd0);
		issue(OP_INSERT, 31'd0);
		issue(OP_INSERT, 31'd64);
		issue(OP_INSERT, KEY_TOP);
		issue(OP_INSERT, 31'd127);
		issue(OP_SEARCH, 31'd64);
		issue(OP_REMOVE, 31'd0);
		issue(OP_SEARCH, 31'd64);
		issue(OP_SEARCH, 31'd0);
		issue(OP_INSERT, 31'd128);
		issue(OP_REMOVE, 31'd0);
		issue(OP_CLEAR, KEY_TOP);
		issue(OP_SEARCH, 31'd64);

		// single slot: full table, exhausted probe, tombstone reuse
		set_size(7'd1);
		issue(OP_INSERT, 31'd5);
		issue(OP_INSERT, 31'd6);
		issue(OP_SEARCH, 31'd6);
		issue(OP_REMOVE, 31'd5);
		issue(OP_SEARCH, 31'd5);
		issue(OP_INSERT, 31'd6);

		// size zero behaves as one
		set_size(7'd0);
		issue(OP_INSERT, 31'd7);

		// oversize saturates to the full memory
		set_size(7'd127);
		issue(OP_SEARCH, 31'd6);
		issue(OP_INSERT, 31'd6);

		// shrink with keys held: slots kept, upper ones not probed
		set_size(7'd3);
		issue(OP_SEARCH, 31'd6);
		issue(OP_CLEAR, 31'd0);

		// random rounds over a range of sizes
		for (int round = 0; round < ROUNDS; round++) begin
			case (round)
				0: new_size = 7'd64;
				1: new_size = 7'd1;
				2: new_size = 7'd2;
				3: new_size = 7'd5;
				4: new_size = 7'd8;
				5: new_size = 7'd16;
				6: new_size = 7'd37;
				7: new_size = 7'd100;
				8: new_size = TSIZE_W'($urandom_range(1, 127));
				9: new_size = 7'd13;
				default: new_size = 7'd3;
			endcase
			set_size(new_size);
			n_slots = (new_size == 0) ? 1 : ((new_size > MAX_SLOTS_D) ? MAX_SLOTS_D : new_size);
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1) == 1) issue(OP_CLEAR, KEY_W'($urandom));
			build_pool(n_slots);
			repeat (ROUND_ITEMS) begin
				if ($urandom_range(0, 99) < 85)
					issue(pick_op(), key_pool[$urandom_range(0, pool_len - 1)]);
				else
					issue(pick_op(), KEY_W'($urandom));
			end
		end

		// drain and verdict
		start <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

[filelist.f]
design/ohash_pkg.sv
design/ohash_mod.sv
design/ohash_mem.sv
design/open_addressing_hash_table.sv
bench/hash_table_checker.sv
bench/tb.sv
